// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// each macro needs clk and arst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/evfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_pkg
// Shared types, sizes and helpers of the event flag group.
// ----------------------------------------------------------------------------
package evfg_pkg;

	// sizes
	localparam int WAITERS   = 8;
	localparam int FLAG_BITS = 32;
	localparam int IN_W      = 32;
	localparam int TASK_W    = 8;
	localparam int CNT_W     = $clog2(WAITERS + 1);
	localparam int IDX_W     = (WAITERS > 1) ? $clog2(WAITERS) : 1;

	typedef logic [FLAG_BITS-1:0] flag_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;

	// request kinds
	typedef enum logic [1:0] {
		KIND_SEND   = 2'd0,
		KIND_RECV   = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_PENDED     = 3'd1,
		STAT_NO_WAIT    = 3'd2,
		STAT_FULL       = 3'd3,
		STAT_NONE_WOKEN = 3'd4,
		STAT_ZERO_SEND  = 3'd5,
		STAT_CANCELLED  = 3'd6,
		STAT_NOT_FOUND  = 3'd7
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [TASK_W-1:0] task_id;
		logic [IN_W-1:0]   flag_bits;
		logic              wait_all;
		logic              may_wait;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [TASK_W-1:0] task_out;
		logic [IN_W-1:0]   received_bits;
		logic              last;
	} res_t;

	// one waiting task
	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		flag_t             mask;
		logic              wait_all;
	} waiter_t;

	// table control from the sequencer
	typedef struct packed {
		logic    append;
		logic    remove;
		idx_t    idx;
		waiter_t entry;
	} tbl_ctl_t;

	// port-width bits to flag width, extra bits dropped
	function automatic flag_t to_flags(input logic [IN_W-1:0] b);
		logic [FLAG_BITS+IN_W-1:0] wide;
		wide = {{FLAG_BITS{1'b0}}, b};
		return wide[FLAG_BITS-1:0];
	endfunction

	// flag width back to port width
	function automatic logic [IN_W-1:0] to_port(input flag_t f);
		logic [FLAG_BITS+IN_W-1:0] wide;
		wide = {{IN_W{1'b0}}, f};
		return wide[IN_W-1:0];
	endfunction

endpackage

// ===== hdl/evfg_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_table
// FIFO table of waiting tasks: append at the tail, remove at any index with
// the younger entries closing the gap, one read port at the walk index.
// ----------------------------------------------------------------------------
module evfg_table (
	input  logic                clk,
	input  logic                arst_n,
	input  evfg_pkg::tbl_ctl_t  ctl,
	output evfg_pkg::cnt_t      count,
	output evfg_pkg::waiter_t   rd_entry
);
	import evfg_pkg::*;

	waiter_t entry_q [WAITERS];
	cnt_t    count_q;

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.remove) begin
			for (int j = 0; j < WAITERS - 1; j++) begin
				if (IDX_W'(j) >= ctl.idx) begin
					entry_q[j] <= entry_q[j + 1];
				end
			end
		end else if (ctl.append) begin
			entry_q[count_q[IDX_W-1:0]] <= ctl.entry;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.remove) begin
			count_q <= count_q - CNT_W'(1);
		end else if (ctl.append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign count    = count_q;
	assign rd_entry = entry_q[ctl.idx];

endmodule

// ===== hdl/event_flag_group.sv =====
`timescale 1ns / 1ps
// States: receive ST_RECV, cancel ST_CANCEL, send ST_WALK (not a zero send), ST_EMIT
// Throughput: one request at a time; a send or cancel walks the table one entry per
// cycle; a send uses the mask compare shared with receive and waits on result stalls
// Result waits in an output register; a send's wakings each take one result slot
// Reset: asynchronous, flag set and waiter count cleared, table contents unused
// ----------------------------------------------------------------------------
// event_flag_group
// One event-flag object: flag set, receive/send/cancel sequencer and waiter
// table, with one result register toward the consumer.
// ----------------------------------------------------------------------------
module event_flag_group (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  evfg_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output evfg_pkg::res_t res
);
	import evfg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECV,
		ST_WALK,
		ST_CANCEL,
		ST_EMIT
	} state_t;

	state_t   state_q;
	req_t     item_q;
	flag_t    flags_q;
	cnt_t     idx_q;
	logic     woke_q;
	res_t     pend_q;
	res_t     out_q;
	logic     out_valid_q;

	tbl_ctl_t tbl_ctl;
	cnt_t     tbl_count;
	waiter_t  tbl_entry;

	flag_t    item_mask;
	flag_t    op_mask;
	logic     op_all;
	flag_t    hit;
	flag_t    flags_left;
	logic     match;
	logic     in_range;
	logic     out_free;
	logic     can_push;
	logic     task_hit;

	assign item_mask = to_flags(item_q.flag_bits);
	assign in_range  = idx_q < tbl_count;
	assign out_free  = !out_valid_q || !res_stall;
	assign can_push  = !woke_q || out_free;
	assign task_hit  = tbl_entry.task_id == item_q.task_id;

	// shared mask compare: receive mask or the table entry under the walk
	always_comb begin
		op_mask    = (state_q == ST_RECV) ? item_mask : tbl_entry.mask;
		op_all     = (state_q == ST_RECV) ? item_q.wait_all : tbl_entry.wait_all;
		hit        = flags_q & op_mask;
		match      = op_all ? (hit == op_mask) : (hit != '0);
		flags_left = flags_q & ~op_mask;
	end

	// table control
	always_comb begin
		tbl_ctl.append = (state_q == ST_RECV) && !match && item_q.may_wait
			&& (tbl_count != CNT_W'(WAITERS));
		tbl_ctl.remove = ((state_q == ST_WALK) && in_range && match && can_push)
			|| ((state_q == ST_CANCEL) && in_range && task_hit);
		tbl_ctl.idx    = idx_q[IDX_W-1:0];
		tbl_ctl.entry  = '{task_id: item_q.task_id, mask: item_mask,
			wait_all: item_q.wait_all};
	end

	evfg_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.count    (tbl_count),
		.rd_entry (tbl_entry)
	);

	// sequencer, flag set and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flags_q     <= '0;
			idx_q       <= '0;
			woke_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						idx_q  <= '0;
						woke_q <= 1'b0;
						unique case (req.kind)
							KIND_SEND: begin
								if (to_flags(req.flag_bits) == '0) begin
									pend_q  <= '{STAT_ZERO_SEND, '0, '0, 1'b1};
									state_q <= ST_EMIT;
								end else begin
									flags_q <= flags_q | to_flags(req.flag_bits);
									state_q <= ST_WALK;
								end
							end
							KIND_RECV:   state_q <= ST_RECV;
							KIND_CANCEL: state_q <= ST_CANCEL;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RECV: begin
					priority if (match) begin
						flags_q <= flags_left;
						pend_q  <= '{STAT_OK, item_q.task_id, to_port(hit), 1'b1};
					end else if (!item_q.may_wait) begin
						pend_q <= '{STAT_NO_WAIT, item_q.task_id, '0, 1'b1};
					end else if (tbl_count == CNT_W'(WAITERS)) begin
						pend_q <= '{STAT_FULL, item_q.task_id, '0, 1'b1};
					end else begin
						pend_q <= '{STAT_PENDED, item_q.task_id, '0, 1'b1};
					end
					state_q <= ST_EMIT;
				end
				ST_WALK: begin
					priority if (!in_range) begin
						if (!woke_q) begin
							pend_q <= '{STAT_NONE_WOKEN, '0, '0, 1'b1};
						end
						state_q <= ST_EMIT;
					end else if (match) begin
						if (can_push) begin
							// previous waking leaves as a non-final result
							if (woke_q) begin
								out_q       <= '{pend_q.status, pend_q.task_out,
									pend_q.received_bits, 1'b0};
								out_valid_q <= 1'b1;
							end
							pend_q  <= '{STAT_OK, tbl_entry.task_id, to_port(hit), 1'b1};
							flags_q <= flags_left;
							woke_q  <= 1'b1;
							if (flags_left == '0) begin
								state_q <= ST_EMIT;
							end
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_CANCEL: begin
					priority if (!in_range) begin
						pend_q  <= '{STAT_NOT_FOUND, item_q.task_id, '0, 1'b1};
						state_q <= ST_EMIT;
					end else if (task_hit) begin
						pend_q  <= '{STAT_CANCELLED, item_q.task_id, '0, 1'b1};
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q       <= '{pend_q.status, pend_q.task_out,
							pend_q.received_bits, 1'b1};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// checks
	`include "assert_macros.svh"

	`ASSERT_IMP(a_count_bound, 1'b1, tbl_count <= CNT_W'(WAITERS))
	`ASSERT_IMP(a_walk_in_table, (state_q == ST_WALK) || (state_q == ST_CANCEL), idx_q <= tbl_count)
	`ASSERT_IMP(a_only_ok_not_last, res_valid && (res.status != STAT_OK), res.last)
	`ASSERT_IMP(a_bits_only_ok, res_valid && (res.received_bits != '0), res.status == STAT_OK)

endmodule

// ===== dv/event_flag_group_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_test
// Self-checking bench for the event flag group. A driver feeds requests from
// a pending queue, a shadow model of the flag set and waiter table predicts
// every result, and a monitor checks each result field by field in order.
// Sender gaps and receiver stalls change by phase over the run.
// ----------------------------------------------------------------------------
module event_flag_group_test;
	import evfg_pkg::*;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 340;
	localparam int TAIL_CYCLES  = 20;
	localparam int PHASE_LEN    = 45;

	typedef struct {
		req_t r;
		bit   drain;
	} stim_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	stim_t pending_q[$];
	res_t  expected_res[$];

	// shadow copy of the flag object
	flag_t             shadow_flags = '0;
	logic [TASK_W-1:0] shadow_tid[WAITERS];
	flag_t             shadow_mask[WAITERS];
	logic              shadow_all[WAITERS];
	int                shadow_count = 0;

	int error_count  = 0;
	int accepted_cnt = 0;
	int cycle_count;
	int phase;
	int idle_pct[4]  = '{0, 62, 0, 15};
	int stall_pct[4] = '{0, 0, 62, 15};
	logic drv_busy;
	res_t got_res;
	res_t want_res;

	event_flag_group u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic res_t make_res(input status_t st, input logic [TASK_W-1:0] tid,
			input logic [IN_W-1:0] bits, input logic fin);
		res_t o;
		o.status        = st;
		o.task_out      = tid;
		o.received_bits = bits;
		o.last          = fin;
		return o;
	endfunction

	// all or any test against the shadow set
	function automatic logic flags_match(input flag_t mask, input logic all_mode);
		flag_t hit;
		hit = shadow_flags & mask;
		return all_mode ? (hit == mask) : (hit != '0);
	endfunction

	// drop one waiter, keeping the table oldest first
	task automatic remove_waiter(input int idx);
		for (int j = idx; j + 1 < shadow_count; j++) begin
			shadow_tid[j]  = shadow_tid[j + 1];
			shadow_mask[j] = shadow_mask[j + 1];
			shadow_all[j]  = shadow_all[j + 1];
		end
		shadow_count--;
	endtask

	// update the shadow object and queue the results of one request
	task automatic predict_flag_results(input req_t r);
		flag_t bits;
		flag_t got;
		res_t  held;
		logic  have_held;
		int    i;
		logic  found;
		bits      = r.flag_bits;
		have_held = 1'b0;
		found     = 1'b0;
		case (r.kind)
			KIND_SEND: begin
				if (bits == '0) begin
					expected_res.push_back(make_res(STAT_ZERO_SEND, '0, '0, 1'b1));
				end else begin
					shadow_flags = shadow_flags | bits;
					i = 0;
					while (i < shadow_count) begin
						if (flags_match(shadow_mask[i], shadow_all[i])) begin
							got          = shadow_flags & shadow_mask[i];
							shadow_flags = shadow_flags & ~shadow_mask[i];
							if (have_held)
								expected_res.push_back(held);
							held      = make_res(STAT_OK, shadow_tid[i], got, 1'b0);
							have_held = 1'b1;
							remove_waiter(i);
							if (shadow_flags == '0)
								break;
						end else begin
							i++;
						end
					end
					if (have_held) begin
						held.last = 1'b1;
						expected_res.push_back(held);
					end else begin
						expected_res.push_back(make_res(STAT_NONE_WOKEN, '0, '0, 1'b1));
					end
				end
			end
			KIND_RECV: begin
				if (flags_match(bits, r.wait_all)) begin
					got          = shadow_flags & bits;
					shadow_flags = shadow_flags & ~bits;
					expected_res.push_back(make_res(STAT_OK, r.task_id, got, 1'b1));
				end else if (!r.may_wait) begin
					expected_res.push_back(make_res(STAT_NO_WAIT, r.task_id, '0, 1'b1));
				end else if (shadow_count >= WAITERS) begin
					expected_res.push_back(make_res(STAT_FULL, r.task_id, '0, 1'b1));
				end else begin
					shadow_tid[shadow_count]  = r.task_id;
					shadow_mask[shadow_count] = bits;
					shadow_all[shadow_count]  = r.wait_all;
					shadow_count++;
					expected_res.push_back(make_res(STAT_PENDED, r.task_id, '0, 1'b1));
				end
			end
			KIND_CANCEL: begin
				for (i = 0; i < shadow_count && !found; i++) begin
					if (shadow_tid[i] == r.task_id) begin
						remove_waiter(i);
						found = 1'b1;
					end
				end
				expected_res.push_back(make_res(found ? STAT_CANCELLED : STAT_NOT_FOUND,
					r.task_id, '0, 1'b1));
			end
			default: begin
				// unused kind: no result
			end
		endcase
	endtask

	task automatic add_request(input logic [1:0] kind, input logic [TASK_W-1:0] tid,
			input logic [IN_W-1:0] bits, input logic all_mode, input logic may,
			input bit drain);
		stim_t s;
		s.r.kind      = kind_t'(kind);
		s.r.task_id   = tid;
		s.r.flag_bits = bits;
		s.r.wait_all  = all_mode;
		s.r.may_wait  = may;
		s.drain       = drain;
		pending_q.push_back(s);
	endtask

	// mostly sparse masks so that waiters pile up and get woken
	function automatic logic [IN_W-1:0] rand_bits();
		logic [IN_W-1:0] b;
		case ($urandom_range(9))
			0, 1, 2, 3: b = 32'h1 << $urandom_range(31);
			4, 5, 6: b = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31))
				| (32'h1 << $urandom_range(31));
			7: b = $urandom;
			8: b = $urandom & $urandom & $urandom;
			default: b = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
		endcase
		return b;
	endfunction

	function automatic logic [TASK_W-1:0] rand_tid();
		return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
	endfunction

	// idling phase follows the number of accepted requests
	assign phase = (accepted_cnt / PHASE_LEN) % 4;

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			drv_busy = req_valid;
			if (req_valid && !req_stall) begin
				predict_flag_results(req);
				void'(pending_q.pop_front());
				accepted_cnt++;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (pending_q.size() != 0
						&& !(pending_q[0].drain && expected_res.size() != 0)
						&& $urandom_range(99) >= idle_pct[phase]) begin
					req_valid <= 1'b1;
					req       <= pending_q[0].r;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				got_res = res;
				if (expected_res.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: status %0d task %0d",
						got_res.status, got_res.task_out));
				end else begin
					want_res = expected_res.pop_front();
					if (got_res.status != want_res.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							got_res.status, want_res.status));
					if (got_res.task_out != want_res.task_out)
						report_mismatch($sformatf("task_out %0d, expected %0d",
							got_res.task_out, want_res.task_out));
					if (got_res.received_bits != want_res.received_bits)
						report_mismatch($sformatf("received_bits %h, expected %h",
							got_res.received_bits, want_res.received_bits));
					if (got_res.last != want_res.last)
						report_mismatch($sformatf("last %0d, expected %0d",
							got_res.last, want_res.last));
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct[phase]);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int counted;
		int pick;

		// directed part
		add_request(KIND_SEND,   8'h00, 32'h0000_0000, 1'b0, 1'b0, 0); // zero send
		add_request(KIND_SEND,   8'h00, 32'h0000_0001, 1'b0, 1'b0, 0); // nobody woken
		add_request(KIND_RECV,   8'h10, 32'h0000_0001, 1'b0, 1'b0, 0); // any match
		add_request(KIND_RECV,   8'h11, 32'h0000_0000, 1'b1, 1'b0, 0); // zero mask, all
		add_request(KIND_RECV,   8'h12, 32'h0000_0000, 1'b0, 1'b0, 0); // zero mask, any
		add_request(KIND_RECV,   8'h00, 32'h0000_0000, 1'b0, 1'b1, 0); // pends, zero mask never matches any
		add_request(KIND_RECV,   8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 0);
		add_request(KIND_RECV,   8'h01, 32'h8000_0000, 1'b0, 1'b1, 0);
		add_request(KIND_RECV,   8'h02, 32'h0000_0003, 1'b1, 1'b1, 0);
		add_request(KIND_RECV,   8'h02, 32'h0000_0001, 1'b0, 1'b1, 0); // duplicate task
		add_request(KIND_RECV,   8'h03, 32'h0000_0100, 1'b0, 1'b1, 0);
		add_request(KIND_RECV,   8'h04, 32'h0001_0000, 1'b0, 1'b1, 0);
		add_request(KIND_RECV,   8'h05, 32'h0000_0002, 1'b0, 1'b1, 0); // table now full
		add_request(KIND_RECV,   8'h06, 32'h0000_0004, 1'b0, 1'b1, 0); // full table
		add_request(KIND_CANCEL, 8'h77, 32'h0000_0000, 1'b0, 1'b0, 0); // not found
		add_request(KIND_CANCEL, 8'h02, 32'h0000_0000, 1'b0, 1'b0, 0); // oldest of two
		add_request(KIND_SEND,   8'h00, 32'h8000_0103, 1'b0, 1'b0, 0); // wakes until empty
		add_request(KIND_SEND,   8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 0);
		add_request(2'd3,        8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 0); // ignored kind
		add_request(KIND_CANCEL, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 0);
		add_request(KIND_CANCEL, 8'h04, 32'h0000_0000, 1'b0, 1'b0, 0);
		add_request(KIND_RECV,   8'hAA, 32'h5555_5555, 1'b1, 1'b1, 0);
		add_request(KIND_SEND,   8'h00, 32'hAAAA_AAAA, 1'b0, 1'b0, 1); // after drain
		add_request(KIND_SEND,   8'h00, 32'h5555_5555, 1'b0, 1'b0, 0);

		// random part, ignored kinds not counted
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 40)
				add_request(KIND_RECV, rand_tid(), rand_bits(), 1'($urandom_range(1)),
					1'($urandom_range(4) != 0), (counted % 97) == 50);
			else if (pick < 75)
				add_request(KIND_SEND, 8'($urandom), rand_bits(), 1'($urandom_range(1)),
					1'($urandom_range(1)), (counted % 97) == 50);
			else if (pick < 94)
				add_request(KIND_CANCEL, rand_tid(), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)), (counted % 97) == 50);
			else
				add_request(2'd3, 8'($urandom), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)), 0);
			if (pick < 94)
				counted++;
		end

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		@(posedge clk);
		while (pending_q.size() != 0 || req_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_res.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_res.size()));

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== event_flag_group.f =====
+incdir+hdl
hdl/evfg_pkg.sv
hdl/evfg_table.sv
hdl/event_flag_group.sv
dv/event_flag_group_test.sv
